>>> sv/imu_deframe_pkg.sv
// Package: shared types and constants for the IMU frame deframer.
package imu_deframe_pkg;

    localparam int MAX_PAYLOAD_DEF = 255;

    localparam logic [7:0] HDR_FIRST  = 8'h59;
    localparam logic [7:0] HDR_SECOND = 8'h53;

    localparam logic [7:0] ID_ACCEL = 8'h10;
    localparam logic [7:0] ID_GYRO  = 8'h20;
    localparam logic [7:0] ID_EUL   = 8'h30;
    localparam logic [7:0] ID_EUL2  = 8'h31;
    localparam logic [7:0] ID_MAG   = 8'h40;
    localparam logic [7:0] ID_QUAT  = 8'h41;

    localparam logic [7:0] LEN_TRIPLE = 8'd12;
    localparam logic [7:0] LEN_QUAD   = 8'd16;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_sums;   // start of frame
        logic take_tid_lo;
        logic take_tid_hi;
        logic take_len;
        logic take_pay;     // store and sum a payload byte
        logic take_cka;
        logic take_ckb;
        logic scan_start;   // load scan pointer with zero
        logic scan_fetch;   // advance fetch address by one
        logic scan_shift;   // shift read byte into window
        logic scan_skip;    // advance pointer by one
        logic scan_jump;    // advance pointer past entry
        logic load_record;
        logic load_status;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pay_last;     // this payload byte completes the frame
        logic len_zero;
        logic check_bad;
        logic scan_done;    // pointer reached limit
        logic entry_hit;    // window holds a known, fitting entry
    } dp_stat_t;

    // Length of entry for a data id, zero if unknown
    function automatic logic [7:0] entry_len(input logic [7:0] id);
        logic [7:0] r;
        begin
            case (id)
                ID_ACCEL, ID_GYRO, ID_EUL, ID_EUL2, ID_MAG: r = LEN_TRIPLE;
                ID_QUAT: r = LEN_QUAD;
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/imu_deframe_dp.sv
// Datapath: frame fields, checksum, payload memory, scan window, output register.
module imu_deframe_dp #(
    parameter int MAX_PAYLOAD = imu_deframe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                rx_byte,
    input  imu_deframe_pkg::dp_cmd_t  cmd,
    output imu_deframe_pkg::dp_stat_t stat,
    output logic                      item_kind,
    output logic [7:0]                record_id,
    output logic signed [31:0]        value_a,
    output logic signed [31:0]        value_b,
    output logic signed [31:0]        value_c,
    output logic signed [31:0]        value_d,
    output logic [2:0]                value_count,
    output logic                      frame_status,
    output logic [15:0]               transaction_id,
    output logic                      last_of_run
);
    import imu_deframe_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int WIN = 18;

    logic [7:0]  len_reg;
    logic [8:0]  idx_reg;
    logic [7:0]  suma_reg, sumb_reg;
    logic [15:0] tid_reg, chk_reg;
    logic [8:0]  pos_reg;      // scan pointer of window start
    logic [8:0]  fetch_reg;    // next fetch address
    logic [7:0]  mem [MAX_PAYLOAD];
    logic [7:0]  rd_reg;
    logic [7:0]  win_reg [WIN];
    logic [8:0]  limit;
    logic [7:0]  suma_next;
    logic [7:0]  need;
    logic [9:0]  end_pos;

    assign limit = ({1'b0, len_reg} > 9'(MAX_PAYLOAD)) ? 9'(MAX_PAYLOAD) : {1'b0, len_reg};
    assign suma_next = suma_reg + rx_byte;

    // Frame fields and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            idx_reg  <= '0;
            suma_reg <= '0;
            sumb_reg <= '0;
            tid_reg  <= '0;
            chk_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_sums)
            begin
                suma_reg <= '0;
                sumb_reg <= '0;
                idx_reg  <= '0;
            end
            if (cmd.take_tid_lo || cmd.take_tid_hi || cmd.take_len || cmd.take_pay)
            begin
                suma_reg <= suma_next;
                sumb_reg <= sumb_reg + suma_next;
            end
            if (cmd.take_tid_lo)
                tid_reg <= {8'd0, rx_byte};
            if (cmd.take_tid_hi)
                tid_reg[15:8] <= rx_byte;
            if (cmd.take_len)
            begin
                len_reg <= rx_byte;
                idx_reg <= '0;
            end
            if (cmd.take_pay)
                idx_reg <= idx_reg + 9'd1;
            if (cmd.take_cka)
                chk_reg <= {8'd0, rx_byte};
            if (cmd.take_ckb)
                chk_reg[15:8] <= rx_byte;
        end
    end

    // Payload memory
    always_ff @(posedge clk)
    begin
        if (cmd.take_pay && idx_reg < 9'(MAX_PAYLOAD))
            mem[idx_reg[AW-1:0]] <= rx_byte;
        if (fetch_reg < 9'(MAX_PAYLOAD))
            rd_reg <= mem[fetch_reg[AW-1:0]];
        else
            rd_reg <= 8'd0;
    end

    // Scan window: win_reg[0] is the byte at pos_reg
    assign need = entry_len(win_reg[0]);
    assign end_pos = {1'b0, pos_reg} + 10'd2 + {2'b0, need};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fetch_reg <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                pos_reg   <= '0;
                fetch_reg <= '0;
            end
            if (cmd.scan_fetch)
                fetch_reg <= fetch_reg + 9'd1;
            if (cmd.scan_skip)
            begin
                pos_reg   <= pos_reg + 9'd1;
                fetch_reg <= pos_reg + 9'd1;
            end
            if (cmd.scan_jump)
            begin
                pos_reg   <= end_pos[8:0];
                fetch_reg <= end_pos[8:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_shift)
        begin
            for (int i = 0; i < WIN - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[WIN-1] <= rd_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.pay_last  = ({1'b0, idx_reg} + 10'd1) >= {2'b0, len_reg};
        stat.len_zero  = (rx_byte == 8'd0);
        stat.check_bad = ({sumb_reg, suma_reg} != chk_reg);
        stat.scan_done = (pos_reg >= limit);
        stat.entry_hit = (need != 8'd0) && (({1'b0, pos_reg} + 10'd1) < {1'b0, limit})
                         && (win_reg[1] == need) && (end_pos <= {1'b0, limit});
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_kind <= KIND_RECORD;
            last_of_run <= 1'b0;
        end
        else if (cmd.load_record)
        begin
            item_kind <= KIND_RECORD;
            last_of_run <= 1'b0;
        end
        else if (cmd.load_status)
        begin
            item_kind <= KIND_STATUS;
            last_of_run <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_record)
        begin
            record_id      <= win_reg[0];
            value_a        <= {win_reg[5], win_reg[4], win_reg[3], win_reg[2]};
            value_b        <= {win_reg[9], win_reg[8], win_reg[7], win_reg[6]};
            value_c        <= {win_reg[13], win_reg[12], win_reg[11], win_reg[10]};
            value_d        <= (need == LEN_QUAD) ?
                              {win_reg[17], win_reg[16], win_reg[15], win_reg[14]} : 32'd0;
            value_count    <= (need == LEN_QUAD) ? 3'd4 : 3'd3;
            frame_status   <= 1'b0;
            transaction_id <= tid_reg;
        end
        else if (cmd.load_status)
        begin
            record_id      <= 8'd0;
            value_a        <= '0;
            value_b        <= '0;
            value_c        <= '0;
            value_d        <= '0;
            value_count    <= 3'd0;
            frame_status   <= stat.check_bad;
            transaction_id <= tid_reg;
        end
    end

endmodule

>>> sv/imu_deframe_ctrl.sv
// Controller: receive phases, payload scan sequencing and output handshake.
module imu_deframe_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  imu_deframe_pkg::dp_stat_t stat,
    output imu_deframe_pkg::dp_cmd_t  cmd
);
    import imu_deframe_pkg::*;

    typedef enum logic [11:0] {
        ST_HUNT1 = 12'b000000000001,
        ST_HUNT2 = 12'b000000000010,
        ST_TIDLO = 12'b000000000100,
        ST_TIDHI = 12'b000000001000,
        ST_LEN   = 12'b000000010000,
        ST_PAY   = 12'b000000100000,
        ST_CKA   = 12'b000001000000,
        ST_CKB   = 12'b000010000000,
        ST_FILL  = 12'b000100000000,
        ST_EVAL  = 12'b001000000000,
        ST_EMIT  = 12'b010000000000,
        ST_FINAL = 12'b100000000000
    } state_t;

    localparam logic [4:0] FILL_CYCLES = 5'd19; // 18 window bytes plus the registered memory read

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;
    logic       take;

    assign out_valid = ovalid_reg;
    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_HUNT1:
            begin
                in_ready = 1'b1;
                if (take && rx_byte == HDR_FIRST)
                    state_next = ST_HUNT2;
            end
            ST_HUNT2:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        state_next = ST_TIDLO;
                        cmd.clear_sums = 1'b1;
                    end
                    else if (rx_byte != HDR_FIRST)
                        state_next = ST_HUNT1;
                end
            end
            ST_TIDLO:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_tid_lo = 1'b1;
                    state_next = ST_TIDHI;
                end
            end
            ST_TIDHI:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_tid_hi = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_len = 1'b1;
                    state_next = stat.len_zero ? ST_CKA : ST_PAY;
                end
            end
            ST_PAY:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_pay = 1'b1;
                    if (stat.pay_last)
                        state_next = ST_CKA;
                end
            end
            ST_CKA:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_cka = 1'b1;
                    state_next = ST_CKB;
                end
            end
            ST_CKB:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.take_ckb = 1'b1;
                    state_next = ST_EVAL;
                    cmd.scan_start = 1'b1;
                    cnt_next = '0;
                end
            end
            // refill the window from the current pointer
            ST_FILL:
            begin
                cmd.scan_fetch = 1'b1;
                if (cnt_reg != 5'd0)
                    cmd.scan_shift = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == FILL_CYCLES - 5'd1)
                    state_next = ST_EMIT;
            end
            ST_EVAL:
            begin
                // first pass after check bytes: decide good or bad
                if (stat.check_bad)
                    state_next = ST_FINAL;
                else
                begin
                    state_next = ST_FILL;
                    cnt_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (stat.scan_done)
                    state_next = ST_FINAL;
                else if (!stat.entry_hit)
                begin
                    cmd.scan_skip = 1'b1;
                    state_next = ST_FILL;
                    cnt_next = '0;
                end
                else if (!ovalid_reg || out_ready)
                begin
                    cmd.load_record = 1'b1;
                    cmd.scan_jump = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = ST_FILL;
                    cnt_next = '0;
                end
            end
            ST_FINAL:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.load_status = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = ST_HUNT1;
                end
            end
            default:
                state_next = ST_HUNT1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT1;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

>>> sv/imu_frame_deframer.sv
// Top level: byte-serial checksummed IMU frame deframer.
//
//  channel  | handshake              | words
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | rx_byte
//  output   | out_valid / out_ready  | item_kind .. last_of_run
//
// Header, tid, length, payload and check bytes are taken one word per cycle while in_valid is high.
// After the second check byte the payload is scanned through a one-port
// memory: each scan step refills an 18-byte window from the scan pointer,
// and the input waits while the scan runs.
// Reset clears the controller and frame registers; the payload memory is not cleared.
// A stalled output holds its word; the scan waits on it.
module imu_frame_deframer #(
    parameter int MAX_PAYLOAD = imu_deframe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               item_kind,
    output logic [7:0]         record_id,
    output logic signed [31:0] value_a,
    output logic signed [31:0] value_b,
    output logic signed [31:0] value_c,
    output logic signed [31:0] value_d,
    output logic [2:0]         value_count,
    output logic               frame_status,
    output logic [15:0]        transaction_id,
    output logic               last_of_run
);
    import imu_deframe_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    imu_deframe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    imu_deframe_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .stat           (stat),
        .item_kind      (item_kind),
        .record_id      (record_id),
        .value_a        (value_a),
        .value_b        (value_b),
        .value_c        (value_c),
        .value_d        (value_d),
        .value_count    (value_count),
        .frame_status   (frame_status),
        .transaction_id (transaction_id),
        .last_of_run    (last_of_run)
    );

endmodule

>>> sim/imu_frame_deframer_tb.sv
// Testbench for the IMU frame deframer: framed byte stimulus checked against a deframing predictor.
`timescale 1ns / 1ps

module imu_frame_deframer_tb;
    import imu_deframe_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int RANDOM_BYTES   = 420;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        logic [31:0] vd;
        logic [2:0]  count;
        logic        status;
        logic [15:0] tid;
        logic        last;
    } deframe_word_t;

    // Predicts the records and frame status a byte stream produces
    class deframe_scoreboard;
        typedef enum logic [2:0] {
            RX_HUNT1, RX_HUNT2, RX_TID_LO, RX_TID_HI, RX_LEN, RX_PAYLOAD, RX_CHK_A, RX_CHK_B
        } rx_phase_e;

        rx_phase_e     phase;
        logic [7:0]    frame_len;
        int            pay_count;
        logic [7:0]    fl_a;
        logic [7:0]    fl_b;
        logic [15:0]   tid;
        logic [15:0]   chk_rx;
        logic [7:0]    pay[MAX_PAYLOAD_DEF];
        deframe_word_t pending[$];
        int            errors;

        function new();
            phase = RX_HUNT1;
            frame_len = 8'd0;
            pay_count = 0;
            fl_a = 8'd0;
            fl_b = 8'd0;
            tid = 16'd0;
            chk_rx = 16'd0;
            errors = 0;
        endfunction

        function void add_sum(input logic [7:0] b);
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
        endfunction

        function logic [31:0] le_word(input int p);
            logic [31:0] w;
            w = '0;
            for (int k = 0; k < 4; k++)
                if (p + k < MAX_PAYLOAD_DEF)
                    w[8*k +: 8] = pay[p + k];
            return w;
        endfunction

        function int id_length(input logic [7:0] id);
            int n;
            case (id)
                ID_ACCEL, ID_GYRO, ID_EUL, ID_EUL2, ID_MAG: n = 12;
                ID_QUAT: n = 16;
                default: n = 0;
            endcase
            return n;
        endfunction

        // Frame end: scan payload for records, then the status word
        function void close_frame();
            deframe_word_t w;
            int limit;
            int p;
            int need;
            logic bad;
            limit = (frame_len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : frame_len;
            bad = ({fl_b, fl_a} != chk_rx);
            if (!bad)
            begin
                p = 0;
                while (p < limit)
                begin
                    need = id_length(pay[p]);
                    if (need != 0 && p + 1 < limit && pay[p + 1] == need
                        && p + 2 + need <= limit)
                    begin
                        w = '0;
                        w.kind = KIND_RECORD;
                        w.id = pay[p];
                        w.va = le_word(p + 2);
                        w.vb = le_word(p + 6);
                        w.vc = le_word(p + 10);
                        w.vd = (need == 16) ? le_word(p + 14) : 32'd0;
                        w.count = 3'(need / 4);
                        w.tid = tid;
                        pending.push_back(w);
                        p = p + 2 + need;
                    end
                    else
                        p = p + 1;
                end
            end
            w = '0;
            w.kind = KIND_STATUS;
            w.status = bad;
            w.tid = tid;
            w.last = 1'b1;
            pending.push_back(w);
        endfunction

        function void note_byte(input logic [7:0] b);
            case (phase)
                RX_HUNT1:
                    if (b == HDR_FIRST) phase = RX_HUNT2;
                RX_HUNT2:
                    if (b == HDR_SECOND)
                    begin
                        phase = RX_TID_LO;
                        fl_a = 8'd0;
                        fl_b = 8'd0;
                        pay_count = 0;
                    end
                    else if (b != HDR_FIRST)
                        phase = RX_HUNT1;
                RX_TID_LO:
                begin
                    tid = {8'd0, b};
                    add_sum(b);
                    phase = RX_TID_HI;
                end
                RX_TID_HI:
                begin
                    tid[15:8] = b;
                    add_sum(b);
                    phase = RX_LEN;
                end
                RX_LEN:
                begin
                    frame_len = b;
                    add_sum(b);
                    pay_count = 0;
                    phase = (b == 8'd0) ? RX_CHK_A : RX_PAYLOAD;
                end
                RX_PAYLOAD:
                begin
                    if (pay_count < MAX_PAYLOAD_DEF) pay[pay_count] = b;
                    add_sum(b);
                    pay_count = (pay_count + 1) & 9'h1FF;
                    if (pay_count >= frame_len) phase = RX_CHK_A;
                end
                RX_CHK_A:
                begin
                    chk_rx = {8'd0, b};
                    phase = RX_CHK_B;
                end
                default:
                begin
                    chk_rx[15:8] = b;
                    phase = RX_HUNT1;
                    close_frame();
                end
            endcase
        endfunction

        function void report(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
            errors++;
        endfunction

        function void check_word(input deframe_word_t got);
            deframe_word_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, got %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind != e.kind) report("item_kind", 32'(e.kind), 32'(got.kind));
            if (got.id != e.id) report("record_id", 32'(e.id), 32'(got.id));
            if (got.va != e.va) report("value_a", e.va, got.va);
            if (got.vb != e.vb) report("value_b", e.vb, got.vb);
            if (got.vc != e.vc) report("value_c", e.vc, got.vc);
            if (got.vd != e.vd) report("value_d", e.vd, got.vd);
            if (got.count != e.count) report("value_count", 32'(e.count), 32'(got.count));
            if (got.status != e.status) report("frame_status", 32'(e.status), 32'(got.status));
            if (got.tid != e.tid) report("transaction_id", 32'(e.tid), 32'(got.tid));
            if (got.last != e.last) report("last_of_run", 32'(e.last), 32'(got.last));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic               item_kind;
    logic [7:0]         record_id;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic [2:0]         value_count;
    logic               frame_status;
    logic [15:0]        transaction_id;
    logic               last_of_run;

    deframe_scoreboard sb;
    logic [7:0] frame_pay[$];
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         bytes_sent;
    int         quiet_cycles;
    int         rx_stall;
    logic [7:0] known_ids[6];

    imu_frame_deframer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .item_kind(item_kind), .record_id(record_id),
        .value_a(value_a), .value_b(value_b), .value_c(value_c), .value_d(value_d),
        .value_count(value_count), .frame_status(frame_status),
        .transaction_id(transaction_id), .last_of_run(last_of_run)
    );

    always #10 clk = ~clk;

    // Send one word, with an optional random gap in front
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Header, tid, length, frame_pay and both check bytes
    task automatic send_frame(input logic [15:0] tid, input bit corrupt);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] len;
        len = 8'(frame_pay.size());
        a = 8'd0;
        b = 8'd0;
        a += tid[7:0];  b += a;
        a += tid[15:8]; b += a;
        a += len;       b += a;
        foreach (frame_pay[i])
        begin
            a += frame_pay[i];
            b += a;
        end
        if (corrupt) b ^= 8'(1 << $urandom_range(0, 7));
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(tid[7:0]);
        send_byte(tid[15:8]);
        send_byte(len);
        foreach (frame_pay[i]) send_byte(frame_pay[i]);
        send_byte(a);
        send_byte(b);
    endtask

    task automatic push_entry(input logic [7:0] id, input bit wrong_len);
        int need;
        need = (id == ID_QUAT) ? 16 : 12;
        frame_pay.push_back(id);
        frame_pay.push_back(wrong_len ? 8'(need ^ 4) : 8'(need));
        repeat (need) frame_pay.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly entries with random values, some stray bytes, cut to len
    task automatic build_payload(input int len);
        frame_pay.delete();
        while (frame_pay.size() < len)
        begin
            if ($urandom_range(0, 9) < 6)
                push_entry(known_ids[$urandom_range(0, 5)], $urandom_range(0, 15) == 0);
            else
                frame_pay.push_back(8'($urandom_range(0, 255)));
        end
        while (frame_pay.size() > len) void'(frame_pay.pop_back());
    endtask

    task automatic push_le(input logic [31:0] v);
        for (int k = 0; k < 4; k++) frame_pay.push_back(v[8*k +: 8]);
    endtask

    // Output side: check accepted words and draw stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_word({item_kind, record_id, value_a, value_b, value_c, value_d,
                           value_count, frame_status, transaction_id, last_of_run});
            if ($urandom_range(0, 40) == 0) rx_idle_on = !rx_idle_on;
            rx_stall = rx_idle_on ? $urandom_range(0, 15) : 0;
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL imu_frame_deframer");
            $finish;
        end
    end

    initial
    begin
        int r;
        int len;
        bit big_done;
        sb = new();
        known_ids = '{ID_ACCEL, ID_GYRO, ID_EUL, ID_EUL2, ID_MAG, ID_QUAT};
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'd0;
        out_ready = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        bytes_sent = 0;
        quiet_cycles = 0;
        rx_stall = 0;
        big_done = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise, empty frame behind a repeated first header byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_FIRST);
        frame_pay.delete();
        send_frame(16'h0000, 0);

        // Every id once, extreme values, all-ones tid
        frame_pay.delete();
        foreach (known_ids[i])
        begin
            frame_pay.push_back(known_ids[i]);
            frame_pay.push_back((known_ids[i] == ID_QUAT) ? LEN_QUAD : LEN_TRIPLE);
            push_le(32'h8000_0000);
            push_le(32'h7FFF_FFFF);
            push_le(32'hFFFF_FFFF);
            if (known_ids[i] == ID_QUAT) push_le(32'h0000_0000);
        end
        send_frame(16'hFFFF, 0);

        // Checksum mismatch, then an entry that does not fit
        build_payload(14);
        send_frame(16'h1234, 1);
        frame_pay.delete();
        frame_pay.push_back(ID_ACCEL);
        frame_pay.push_back(LEN_TRIPLE);
        repeat (5) frame_pay.push_back(8'hA5);
        send_frame(16'h00FF, 0);

        // Hold off until the block has drained
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);

        // Random frames, broken frames and noise
        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0) tx_idle_on = !tx_idle_on;
            r = $urandom_range(0, 19);
            if (r < 16)
            begin
                if (!big_done && bytes_sent > RANDOM_BYTES / 2)
                begin
                    len = 255;
                    big_done = 1;
                end
                else
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, 40);
                build_payload(len);
                send_frame(16'($urandom_range(0, 65535)), 0);
            end
            else if (r < 18)
            begin
                build_payload($urandom_range(0, 30));
                send_frame(16'($urandom_range(0, 65535)), 1);
            end
            else
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? HDR_FIRST
                                                          : 8'($urandom_range(0, 255)));
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS imu_frame_deframer");
        else
            $display("FAIL imu_frame_deframer");
        $finish;
    end

endmodule

>>> imu_frame_deframer.f
sv/imu_deframe_pkg.sv
sv/imu_deframe_dp.sv
sv/imu_deframe_ctrl.sv
sv/imu_frame_deframer.sv
sim/imu_frame_deframer_tb.sv
